// File: rtl/macc_pkg.sv
`timescale 1ns / 1ps

package macc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFER_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARB_TICKS  = 3'd6;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration reset values
    localparam logic [7:0]  RST_INIT_MASK  = 8'd3;
    localparam logic [15:0] RST_DEFER_MS   = 16'd10;
    localparam logic [7:0]  RST_TX_TIMEOUT = 8'd2;

    // Event opcodes
    localparam logic [3:0] OP_RTS     = 4'd0;
    localparam logic [3:0] OP_CTS     = 4'd1;
    localparam logic [3:0] OP_DS      = 4'd2;
    localparam logic [3:0] OP_DACK    = 4'd3;
    localparam logic [3:0] OP_DATA_US = 4'd4;
    localparam logic [3:0] OP_FOREIGN = 4'd5;
    localparam logic [3:0] OP_TX_DONE = 4'd6;
    localparam logic [3:0] OP_LOOP    = 4'd7;
    localparam logic [3:0] OP_STATUS  = 4'd8;

    // Pending send codes
    localparam logic [2:0] PS_NONE = 3'd0;
    localparam logic [2:0] PS_RTS  = 3'd1;
    localparam logic [2:0] PS_CTS  = 3'd2;
    localparam logic [2:0] PS_DS   = 3'd3;
    localparam logic [2:0] PS_DATA = 3'd4;
    localparam logic [2:0] PS_DACK = 3'd5;

    // Emitted frame kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_RTS  = 3'd1;
    localparam logic [2:0] KIND_CTS  = 3'd2;
    localparam logic [2:0] KIND_DS   = 3'd3;
    localparam logic [2:0] KIND_DACK = 3'd4;
    localparam logic [2:0] KIND_SLOT = 3'd5;

    localparam logic [2:0] RTS_SLEEP_LOOPS = 3'd4;

    typedef struct packed {
        logic [7:0]  own_id;
        logic [7:0]  peer_id;
        logic [7:0]  init_mask;
        logic [15:0] defer_ms;
        logic [7:0]  tx_timeout_ms;
        logic [31:0] slot_ticks;
        logic [39:0] dack_thr;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  pkt_target_body;
        logic [31:0] now_ms;
        logic [39:0] sys_time;
        logic [39:0] rx_timestamp;
        logic [39:0] slot_offset;
        logic [7:0]  random_value;
    } item_t;

    typedef struct packed {
        logic [2:0] send_kind;
        logic [7:0] send_target;
        logic [2:0] send_state;
        logic       acquiring;
        logic       listening;
    } result_t;

endpackage

// File: rtl/macc_in_if.sv
`timescale 1ns / 1ps

interface macc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [7:0]  pkt_target_body;
    logic [31:0] now_ms;
    logic [39:0] sys_time;
    logic [39:0] rx_timestamp;
    logic [7:0]  slot_number;
    logic [7:0]  random_value;

    modport source (
        output valid, opcode, pkt_target_body, now_ms, sys_time, rx_timestamp,
               slot_number, random_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, pkt_target_body, now_ms, sys_time, rx_timestamp,
               slot_number, random_value,
        output ready
    );
endinterface

// File: rtl/macc_out_if.sv
`timescale 1ns / 1ps

interface macc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] send_kind;
    logic [7:0] send_target;
    logic [2:0] send_state;
    logic       acquiring;
    logic       listening;

    modport source (
        output valid, send_kind, send_target, send_state, acquiring, listening,
        input  ready
    );

    modport sink (
        input  valid, send_kind, send_target, send_state, acquiring, listening,
        output ready
    );
endinterface

// File: rtl/macc_cfg.sv
`timescale 1ns / 1ps

module macc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [macc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [macc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output macc_pkg::cfg_t                     cfg
);

    logic [7:0]  own_id_reg;
    logic [7:0]  peer_id_reg;
    logic [7:0]  init_mask_reg;
    logic [15:0] defer_ms_reg;
    logic [7:0]  tx_timeout_reg;
    logic [31:0] slot_ticks_reg;
    logic [31:0] arb_ticks_reg;
    logic [39:0] dack_thr_reg;
    logic [39:0] dack_thr_next;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg     <= '0;
            peer_id_reg    <= '0;
            init_mask_reg  <= macc_pkg::RST_INIT_MASK;
            defer_ms_reg   <= macc_pkg::RST_DEFER_MS;
            tx_timeout_reg <= macc_pkg::RST_TX_TIMEOUT;
            slot_ticks_reg <= '0;
            arb_ticks_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                macc_pkg::CFG_OWN_ID:     own_id_reg     <= cfg_data[7:0];
                macc_pkg::CFG_PEER_ID:    peer_id_reg    <= cfg_data[7:0];
                macc_pkg::CFG_INIT_MASK:  init_mask_reg  <= cfg_data[7:0];
                macc_pkg::CFG_DEFER_MS:   defer_ms_reg   <= cfg_data[15:0];
                macc_pkg::CFG_TX_TIMEOUT: tx_timeout_reg <= cfg_data[7:0];
                macc_pkg::CFG_SLOT_TICKS: slot_ticks_reg <= cfg_data;
                macc_pkg::CFG_ARB_TICKS:  arb_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // DACK threshold: six slots less the arbitration margin, mod 2^40
    assign dack_thr_next = {6'd0, slot_ticks_reg, 2'b00} + {7'd0, slot_ticks_reg, 1'b0}
                         - {8'd0, arb_ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dack_thr_reg <= '0;
        end
        else
        begin
            dack_thr_reg <= dack_thr_next;
        end
    end

    assign cfg.own_id        = own_id_reg;
    assign cfg.peer_id       = peer_id_reg;
    assign cfg.init_mask     = init_mask_reg;
    assign cfg.defer_ms      = defer_ms_reg;
    assign cfg.tx_timeout_ms = tx_timeout_reg;
    assign cfg.slot_ticks    = slot_ticks_reg;
    assign cfg.dack_thr      = dack_thr_reg;

endmodule

// File: rtl/macc_core.sv
`timescale 1ns / 1ps

module macc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  macc_pkg::item_t     item,
    input  macc_pkg::cfg_t      cfg,
    output macc_pkg::result_t   res
);

    typedef struct packed {
        logic [2:0] ps;
        logic [2:0] sleep;
        logic [7:0] count;
        logic [7:0] mask;
    } acq_t;

    // Backoff count: (1 + (draw & mask)) * 4, wrapped to 8 bits
    function automatic logic [7:0] backoff_from(input logic [7:0] draw, input logic [7:0] m);
        logic [7:0] sum;
        begin
            sum = (draw & m) + 8'd1;
            return {sum[5:0], 2'b00};
        end
    endfunction

    function automatic acq_t try_acquire(input acq_t s, input logic [7:0] draw);
        acq_t r;
        begin
            r = s;
            if (s.sleep != 3'd0)
            begin
                r.sleep = s.sleep - 3'd1;
            end
            else if (s.count != 8'd0)
            begin
                r.count = s.count - 8'd1;
            end
            else if (s.ps == macc_pkg::PS_NONE)
            begin
                r.ps    = macc_pkg::PS_RTS;
                r.count = backoff_from(draw, s.mask);
                r.mask  = {s.mask[6:0], 1'b1};
            end
            return r;
        end
    endfunction

    logic [2:0]  ps_reg, ps_next;
    logic        tx_complete_reg, tx_complete_next;
    logic [2:0]  rts_sleep_reg, rts_sleep_next;
    logic [7:0]  backoff_count_reg, backoff_count_next;
    logic [7:0]  backoff_mask_reg, backoff_mask_next;
    logic        acquiring_reg, acquiring_next;
    logic        listening_reg, listening_next;
    logic [31:0] defer_start_reg, defer_start_next;
    logic        dack_pending_reg, dack_pending_next;
    logic [39:0] slot_start_reg, slot_start_next;
    logic [31:0] last_tx_reg, last_tx_next;

    acq_t        a;
    logic [2:0]  kind;
    logic        for_us;
    logic [39:0] elapsed;
    logic [31:0] since;
    logic [31:0] since_tx;

    // Update the MAC state for one item
    always_comb
    begin
        a.ps              = ps_reg;
        a.sleep           = rts_sleep_reg;
        a.count           = backoff_count_reg;
        a.mask            = backoff_mask_reg;
        tx_complete_next  = tx_complete_reg;
        acquiring_next    = acquiring_reg;
        listening_next    = listening_reg;
        defer_start_next  = defer_start_reg;
        dack_pending_next = dack_pending_reg;
        slot_start_next   = slot_start_reg;
        last_tx_next      = last_tx_reg;
        kind              = macc_pkg::KIND_NONE;
        for_us            = (item.pkt_target_body == cfg.own_id);
        elapsed           = item.sys_time - slot_start_reg;
        since_tx          = item.now_ms - last_tx_reg;
        since             = '0;

        case (item.opcode)
            macc_pkg::OP_RTS:
            begin
                if (for_us && listening_reg)
                begin
                    a.ps = macc_pkg::PS_CTS;
                end
                a.sleep = macc_pkg::RTS_SLEEP_LOOPS;
            end
            macc_pkg::OP_CTS:
            begin
                if (for_us && listening_reg)
                begin
                    a.ps = macc_pkg::PS_DS;
                end
                listening_next   = 1'b0;
                a.mask           = cfg.init_mask;
                a.count          = backoff_from(item.random_value, cfg.init_mask);
                acquiring_next   = 1'b0;
                defer_start_next = item.now_ms;
            end
            macc_pkg::OP_DS:
            begin
                if (acquiring_reg)
                begin
                    a.mask           = cfg.init_mask;
                    a.count          = backoff_from(item.random_value, cfg.init_mask);
                    acquiring_next   = 1'b0;
                    defer_start_next = item.now_ms;
                end
                listening_next = 1'b0;
            end
            macc_pkg::OP_DACK:
            begin
                if (!for_us)
                begin
                    a.mask         = cfg.init_mask;
                    a.count        = backoff_from(item.random_value, cfg.init_mask);
                    a              = try_acquire(a, item.random_value);
                    acquiring_next = 1'b1;
                end
                listening_next = 1'b1;
            end
            macc_pkg::OP_DATA_US:
            begin
                dack_pending_next = 1'b1;
                slot_start_next   = item.rx_timestamp - item.slot_offset;
            end
            macc_pkg::OP_FOREIGN:
            begin
                if (acquiring_reg)
                begin
                    listening_next   = 1'b0;
                    a.mask           = cfg.init_mask;
                    a.count          = backoff_from(item.random_value, cfg.init_mask);
                    acquiring_next   = 1'b0;
                    defer_start_next = item.now_ms;
                end
            end
            macc_pkg::OP_TX_DONE:
            begin
                tx_complete_next = 1'b1;
            end
            macc_pkg::OP_LOOP:
            begin
                // Schedule the DACK once the slot window opens
                if (dack_pending_reg && (elapsed >= cfg.dack_thr))
                begin
                    a.ps              = macc_pkg::PS_DACK;
                    a.mask            = cfg.init_mask;
                    a.count           = backoff_from(item.random_value, cfg.init_mask);
                    a                 = try_acquire(a, item.random_value);
                    acquiring_next    = 1'b1;
                    dack_pending_next = 1'b0;
                end
                // Emit the pending frame when the radio is free
                if (tx_complete_reg)
                begin
                    case (a.ps)
                        macc_pkg::PS_RTS:
                        begin
                            kind = macc_pkg::KIND_RTS;
                            a.ps = macc_pkg::PS_NONE;
                        end
                        macc_pkg::PS_CTS:
                        begin
                            kind = macc_pkg::KIND_CTS;
                            a.ps = macc_pkg::PS_NONE;
                        end
                        macc_pkg::PS_DS:
                        begin
                            kind = macc_pkg::KIND_DS;
                            a.ps = macc_pkg::PS_DATA;
                        end
                        macc_pkg::PS_DATA:
                        begin
                            kind = macc_pkg::KIND_SLOT;
                            a.ps = macc_pkg::PS_NONE;
                        end
                        macc_pkg::PS_DACK:
                        begin
                            kind = macc_pkg::KIND_DACK;
                            a.ps = macc_pkg::PS_NONE;
                        end
                        default: ;
                    endcase
                    if (kind != macc_pkg::KIND_NONE)
                    begin
                        last_tx_next     = item.now_ms;
                        tx_complete_next = 1'b0;
                    end
                end
                if (acquiring_next)
                begin
                    a = try_acquire(a, item.random_value);
                end
            end
            macc_pkg::OP_STATUS:
            begin
                if (since_tx > {24'd0, cfg.tx_timeout_ms})
                begin
                    tx_complete_next = 1'b1;
                end
                if (acquiring_reg)
                begin
                    defer_start_next = item.now_ms;
                end
                since = item.now_ms - defer_start_next;
                if (since >= {16'd0, cfg.defer_ms})
                begin
                    listening_next = 1'b1;
                end
                if (since >= {15'd0, cfg.defer_ms, 1'b0})
                begin
                    a.mask         = cfg.init_mask;
                    a.count        = backoff_from(item.random_value, cfg.init_mask);
                    a              = try_acquire(a, item.random_value);
                    acquiring_next = 1'b1;
                end
            end
            default: ;
        endcase

        ps_next            = a.ps;
        rts_sleep_next     = a.sleep;
        backoff_count_next = a.count;
        backoff_mask_next  = a.mask;
    end

    // Hold state until an item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg            <= macc_pkg::PS_NONE;
            tx_complete_reg   <= 1'b0;
            rts_sleep_reg     <= '0;
            backoff_count_reg <= '0;
            backoff_mask_reg  <= macc_pkg::RST_INIT_MASK;
            acquiring_reg     <= 1'b1;
            listening_reg     <= 1'b1;
            defer_start_reg   <= '0;
            dack_pending_reg  <= 1'b0;
            slot_start_reg    <= '0;
            last_tx_reg       <= '0;
        end
        else if (advance)
        begin
            ps_reg            <= ps_next;
            tx_complete_reg   <= tx_complete_next;
            rts_sleep_reg     <= rts_sleep_next;
            backoff_count_reg <= backoff_count_next;
            backoff_mask_reg  <= backoff_mask_next;
            acquiring_reg     <= acquiring_next;
            listening_reg     <= listening_next;
            defer_start_reg   <= defer_start_next;
            dack_pending_reg  <= dack_pending_next;
            slot_start_reg    <= slot_start_next;
            last_tx_reg       <= last_tx_next;
        end
    end

    // Form the result from the updated state
    assign res.send_kind   = kind;
    assign res.send_target = (kind != macc_pkg::KIND_NONE) ? cfg.peer_id : 8'd0;
    assign res.send_state  = ps_next;
    assign res.acquiring   = acquiring_next;
    assign res.listening   = listening_next;

`ifndef SYNTHESIS
    a_ps_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ps_reg <= macc_pkg::PS_DACK)
        else $error("pending send holds an unused code");

    a_tx_done_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.opcode == macc_pkg::OP_TX_DONE) |=> tx_complete_reg)
        else $error("transmit done did not mark transmit complete");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && kind != macc_pkg::KIND_NONE) |=> !tx_complete_reg)
        else $error("frame emitted but transmit complete still set");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(ps_reg) && $stable(backoff_count_reg)))
        else $error("state changed without an item");
`endif

endmodule

// File: rtl/medium_access_contention_controller.sv
`timescale 1ns / 1ps

// Channel   Role     Payload
// in_ch     sink     opcode, pkt_target_body, now_ms, sys_time, rx_timestamp,
//                    slot_number, random_value
// out_ch    source   send_kind, send_target, send_state, acquiring, listening
// cfg_*     write    cfg_we, cfg_index, cfg_data (no read-back)
//
// One item per cycle sustained while out_ch is not stalled; the result is valid once stage two loads it.
// Stage one registers the item and the slot offset product slot_number * slot_ticks;
// stage two updates the MAC state and loads the result register.
// A stalled output holds the result and at most one item behind it; input ready then drops.
// Reset is asynchronous and active low; configuration returns to its reset values.

module medium_access_contention_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    macc_in_if.sink                          in_ch,
    macc_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [macc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [macc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    macc_pkg::cfg_t    cfg;
    macc_pkg::item_t   item_reg;
    macc_pkg::item_t   item_next;
    macc_pkg::result_t res;
    macc_pkg::result_t res_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    macc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held item on when the result register is free or being taken
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    // Capture the item with its slot offset
    always_comb
    begin
        item_next.opcode          = in_ch.opcode;
        item_next.pkt_target_body = in_ch.pkt_target_body;
        item_next.now_ms          = in_ch.now_ms;
        item_next.sys_time        = in_ch.sys_time;
        item_next.rx_timestamp    = in_ch.rx_timestamp;
        item_next.slot_offset     = {32'd0, in_ch.slot_number} * {8'd0, cfg.slot_ticks};
        item_next.random_value    = in_ch.random_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= item_next;
        end
    end

    macc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.send_kind   = res_reg.send_kind;
    assign out_ch.send_target = res_reg.send_target;
    assign out_ch.send_state  = res_reg.send_state;
    assign out_ch.acquiring   = res_reg.acquiring;
    assign out_ch.listening   = res_reg.listening;

`ifndef SYNTHESIS
    a_s1_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("held item dropped without advancing");

    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.ready && !advance) |=> !out_valid_reg)
        else $error("taken result shown again");
`endif

endmodule
